// ===== design/avc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the audio effect and volume chain.
package avc_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_W     = 3;
  localparam int CNT_W      = 4;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int VOL_W      = 8;

  // Reciprocals for division by constants: floor(x / d) == (x * R) >> SH in the used range.
  localparam logic [23:0] RECIP100    = 24'd10737419;
  localparam int          RECIP100_SH = 30;
  localparam logic [16:0] RECIP255    = 17'd65794;
  localparam int          RECIP255_SH = 24;
  localparam int          RECIPN_SH   = 22;

  localparam logic [VOL_W-1:0] VOL_UNITY        = 8'd100;
  localparam logic [VOL_W-1:0] GUEST_DIRECT_MAX = 8'd100;
  localparam logic [VOL_W-1:0] MASTER_MAX       = 8'd150;

  typedef enum logic [2:0] {
    CFG_SAMPLE_FORMAT = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_EFFECT_MODE   = 3'd2,
    CFG_GUEST_VOLUME  = 3'd3,
    CFG_MASTER_VOLUME = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_SOFT  = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_BASS  = 3'd3,
    MODE_MONO  = 3'd4
  } effect_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Signed division by 2**sh that truncates toward zero.
  function automatic logic signed [20:0] sdiv_p2(input logic signed [20:0] x,
                                                 input logic [2:0] sh);
    logic signed [20:0] bias;
    bias = x[20] ? ((21'sd1 <<< sh) - 21'sd1) : 21'sd0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] x);
    if (x < -21'sd32768) begin
      return 16'sh8000;
    end else if (x > 21'sd32767) begin
      return 16'sh7fff;
    end else begin
      return x[15:0];
    end
  endfunction

  function automatic logic [7:0] sat_byte(input logic signed [17:0] x);
    if (x < 18'sd0) begin
      return 8'd0;
    end else if (x > 18'sd255) begin
      return 8'd255;
    end else begin
      return x[7:0];
    end
  endfunction

  // ceil(2**22 / n) for the channel average; exact for sums of up to eight samples.
  function automatic logic [21:0] recip_n(input logic [CNT_W-1:0] n);
    logic [21:0] r;
    unique case (n)
      4'd2:    r = 22'd2097152;
      4'd3:    r = 22'd1398102;
      4'd4:    r = 22'd1048576;
      4'd5:    r = 22'd838861;
      4'd6:    r = 22'd699051;
      4'd7:    r = 22'd599187;
      4'd8:    r = 22'd524288;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/avc_vol_calc.sv =====
// Registered computation of the effective volume percent from guest and master volume.
module avc_vol_calc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [avc_pkg::VOL_W-1:0] guest_i,
  input  logic [avc_pkg::VOL_W-1:0] master_i,
  output logic [avc_pkg::VOL_W-1:0] vol_o
);
  import avc_pkg::*;

  logic [14:0]      gscaled;
  logic [31:0]      gprod;
  logic [6:0]       gp_d, gp_q;
  logic [VOL_W-1:0] m_d, m_q;
  logic [13:0]      prod_d, prod_q;
  logic [37:0]      vprod;
  logic [VOL_W-1:0] vol_d, vol_q;

  // Guest values above the direct range are rescaled from 255 with rounding.
  assign gscaled = 15'(guest_i) * 15'd100 + 15'd127;
  assign gprod   = 32'(gscaled) * 32'(RECIP255);
  assign gp_d    = (guest_i <= GUEST_DIRECT_MAX) ? guest_i[6:0] : 7'(gprod >> RECIP255_SH);
  assign m_d     = (master_i > MASTER_MAX) ? MASTER_MAX : master_i;

  assign prod_d  = 14'(gp_q) * 14'(m_q) + 14'd50;
  assign vprod   = 38'(prod_q) * 38'(RECIP100);
  assign vol_d   = 8'(vprod >> RECIP100_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q   <= 7'd100;
      m_q    <= VOL_UNITY;
      prod_q <= 14'd10050;
      vol_q  <= VOL_UNITY;
    end else begin
      gp_q   <= gp_d;
      m_q    <= m_d;
      prod_q <= prod_d;
      vol_q  <= vol_d;
    end
  end

  assign vol_o = vol_q;

endmodule

// ===== design/audio_effect_and_volume_chain_unit.sv =====
// Top level of the audio effect and volume chain: sequencer, filter memory and datapath.
//
// One input word is one audio frame of eight 16-bit channel samples on
// s_axis_tdata, with s_axis_tlast marking the last frame of a buffer. One output
// word per frame leaves on m_axis_tdata with the same lane layout, and
// m_axis_tlast copies the input flag. Lanes at or above the active channel
// count read as zero. In unsigned 8-bit mode each lane carries a raw byte in
// its low eight bits.
// Channels are processed one per cycle through a four-step pipeline: issue and
// filter memory read, filter update and write back, volume multiply, and
// division by one hundred. A frame is accepted only once the previous frame
// has passed through all active channels and drained from the pipeline; in
// mono mode a summing pass over the active channels and a divide step run first.
// The finished frame sits in an output register, so a new frame is accepted
// while the previous result waits for m_axis_tready. If the receiver stalls
// longer, the block holds the next finished frame and stops accepting input.
// Reset restores the default configuration and marks every filter channel as
// not primed, so no clearing pass is needed; changing the effect mode does the
// same at once.
module audio_effect_and_volume_chain_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // sample_0 .. sample_7, 16 bits each, sample_0 in the lowest bits
  input  logic [avc_pkg::NUM_LANES*avc_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                                             s_axis_tlast,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // result_0 .. result_7, 16 bits each, result_0 in the lowest bits
  output logic [avc_pkg::NUM_LANES*avc_pkg::SAMPLE_W-1:0] m_axis_tdata,
  output logic                                             m_axis_tlast,
  input  logic                                             cfg_we_i,
  input  logic [avc_pkg::CFG_IDX_W-1:0]                    cfg_idx_i,
  input  logic [avc_pkg::CFG_DATA_W-1:0]                   cfg_data_i
);
  import avc_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LIMIT = (MAX_CHANNELS < NUM_LANES) ? MAX_CHANNELS : NUM_LANES;

  // Configuration registers.
  logic             fmt_q;
  logic [CNT_W-1:0] count_q;
  effect_mode_e     mode_q, mode_wr;
  logic [VOL_W-1:0] guest_q, master_q;
  logic             clear_filt;

  // Sequencer.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] ch_q, ch_d;
  logic [CNT_W-1:0] n_act;
  logic             mono_act, filt_act, ch_last;
  logic             accept, issue, sum_en, div_en, load_out;

  // Frame registers.
  logic signed [SAMPLE_W-1:0] in_q   [NUM_LANES];
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] res_q  [NUM_LANES];
  logic signed [SAMPLE_W-1:0] out_q  [NUM_LANES];
  logic                       out_last_q;
  logic                       m_valid_q;

  // Mono average.
  logic signed [19:0]         sum_q, sum_term;
  logic [18:0]                sum_mag;
  logic [40:0]                avg_prod;
  logic [16:0]                avg_mag;
  logic signed [SAMPLE_W-1:0] avg_q;

  // Filter memory and primed flags.
  logic signed [SAMPLE_W-1:0] filt_mem [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic [MAX_CHANNELS-1:0]    primed_q;
  logic                       mem_we;

  // Pipeline stages.
  logic signed [SAMPLE_W-1:0] s_raw, s0_val;
  logic [7:0]                 s_byte;
  logic                       v1_q, v2_q, v3_q, f1_q;
  logic [CNT_W-1:0]           ch1_q, ch2_q, ch3_q;
  logic signed [SAMPLE_W-1:0] s1_q, val2_q, val3_q;
  logic signed [SAMPLE_W-1:0] prev, ysat, val2_d;
  logic signed [20:0]         pe, se, low, y;
  logic signed [16:0]         vx;
  logic signed [25:0]         p2_d, p3_q;
  logic                       p_neg;
  logic [24:0]                p_mag;
  logic [48:0]                q_prod;
  logic [16:0]                q_mag;
  logic signed [17:0]         q_s;
  logic signed [SAMPLE_W-1:0] res_d;
  logic [VOL_W-1:0]           vol;

  avc_vol_calc u_vol (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .guest_i  (guest_q),
    .master_i (master_q),
    .vol_o    (vol)
  );

  // ---------------------------------------------------------------------------
  // Configuration. Modes above mono act as off; a real mode change forgets the
  // filter history by dropping every primed flag.
  // ---------------------------------------------------------------------------
  assign mode_wr    = (cfg_data_i[2:0] > MODE_MONO) ? MODE_OFF : effect_mode_e'(cfg_data_i[2:0]);
  assign clear_filt = cfg_we_i && (cfg_idx_i == CFG_EFFECT_MODE) && (mode_wr != mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      count_q  <= 4'd2;
      mode_q   <= MODE_OFF;
      guest_q  <= VOL_UNITY;
      master_q <= VOL_UNITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SAMPLE_FORMAT: fmt_q    <= cfg_data_i[0];
        CFG_CHANNEL_COUNT: count_q  <= cfg_data_i[CNT_W-1:0];
        CFG_EFFECT_MODE:   mode_q   <= mode_wr;
        CFG_GUEST_VOLUME:  guest_q  <= cfg_data_i;
        CFG_MASTER_VOLUME: master_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; large counts stop at the lane and memory limit.
  always_comb begin
    if (count_q == '0) begin
      n_act = CNT_W'(1);
    end else if (count_q > CNT_W'(LIMIT)) begin
      n_act = CNT_W'(LIMIT);
    end else begin
      n_act = count_q;
    end
  end

  assign mono_act = (mode_q == MODE_MONO) && (n_act >= CNT_W'(2));
  assign filt_act = (mode_q == MODE_SOFT) || (mode_q == MODE_CLEAR) || (mode_q == MODE_BASS);
  assign ch_last  = (ch_q == n_act - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Sequencer: optional mono summing pass and divide step, then one channel issued
  // per cycle, then drain the pipeline and hand the frame to the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    ch_d     = ch_q;
    accept   = 1'b0;
    issue    = 1'b0;
    sum_en   = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          accept  = 1'b1;
          ch_d    = '0;
          state_d = mono_act ? ST_SUM : ST_RUN;
        end
      end
      ST_SUM: begin
        sum_en = 1'b1;
        if (ch_last) begin
          ch_d    = '0;
          state_d = ST_DIV;
        end else begin
          ch_d = ch_q + CNT_W'(1);
        end
      end
      ST_DIV: begin
        div_en  = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        issue = 1'b1;
        ch_d  = ch_q + CNT_W'(1);
        if (ch_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q && (!m_valid_q || m_axis_tready)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // Input frame capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        in_q[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
      end
      last_q <= s_axis_tlast;
    end
  end

  assign s_raw  = in_q[ch_q[LANE_W-1:0]];
  assign s_byte = s_raw[7:0];

  // ---------------------------------------------------------------------------
  // Mono: sum the centred samples, then divide by the channel count with a
  // reciprocal multiply on the magnitude so the quotient truncates toward zero.
  // ---------------------------------------------------------------------------
  assign sum_term = fmt_q ? 20'($signed({~s_byte[7], s_byte[6:0]})) : 20'(s_raw);
  assign sum_mag  = sum_q[19] ? 19'(-sum_q) : 19'(sum_q);
  assign avg_prod = 41'(sum_mag) * 41'(recip_n(n_act));
  assign avg_mag  = 17'(avg_prod >> RECIPN_SH);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= '0;
    end else if (sum_en) begin
      sum_q <= sum_q + sum_term;
    end
    if (div_en) begin
      avg_q <= sum_q[19] ? 16'(-$signed({1'b0, avg_mag})) : 16'(avg_mag);
    end
  end

  // ---------------------------------------------------------------------------
  // Issue step: pick the value for this channel. Filter modes feed the sample
  // in 16-bit form (bytes centred and moved to the high half); the other modes
  // give the pre-volume value directly. The filter memory is read alongside.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (mono_act) begin
      s0_val = fmt_q ? $signed({8'd0, ~avg_q[7], avg_q[6:0]}) : avg_q;
    end else if (filt_act) begin
      s0_val = fmt_q ? $signed({~s_byte[7], s_byte[6:0], 8'd0}) : s_raw;
    end else begin
      s0_val = fmt_q ? $signed({8'd0, s_byte}) : s_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= filt_mem[ch_q[CH_W-1:0]];
    if (mem_we) begin
      filt_mem[ch1_q[CH_W-1:0]] <= low[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Filter step. An unprimed channel starts from its own sample. The stored
  // value is always the lowpass output; clear and bass boost derive the result
  // from it. Reads and writes in one frame touch different channels, and the
  // last write of a frame lands well before the next frame's first read.
  // ---------------------------------------------------------------------------
  assign prev = primed_q[ch1_q[CH_W-1:0]] ? rdata_q : s1_q;
  assign pe   = 21'(prev);
  assign se   = 21'(s1_q);

  always_comb begin
    if (mode_q == MODE_BASS) begin
      low = sdiv_p2((pe <<< 4) - pe + se, 3'd4);
    end else begin
      low = sdiv_p2(pe * 21'sd3 + se, 3'd2);
    end
    priority case (mode_q)
      MODE_CLEAR: y = se + sdiv_p2(se - low, 3'd1);
      MODE_BASS:  y = se + sdiv_p2(low, 3'd2);
      default:    y = low;
    endcase
    ysat = sat16(y);
    if (!f1_q) begin
      val2_d = s1_q;
    end else if (fmt_q) begin
      val2_d = $signed({8'd0, ~ysat[15], ysat[14:8]});
    end else begin
      val2_d = ysat;
    end
  end

  assign mem_we = v1_q && f1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= '0;
    end else if (clear_filt) begin
      primed_q <= '0;
    end else if (mem_we) begin
      primed_q[ch1_q[CH_W-1:0]] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Volume: multiply by the percent, then divide by one hundred with a
  // reciprocal multiply on the magnitude, and saturate to the sample format.
  // ---------------------------------------------------------------------------
  assign vx   = fmt_q ? (17'(val2_q) - 17'sd128) : 17'(val2_q);
  assign p2_d = 26'(vx) * 26'($signed({1'b0, vol}));

  assign p_neg  = p3_q[25];
  assign p_mag  = p_neg ? 25'(-p3_q) : 25'(p3_q);
  assign q_prod = 49'(p_mag) * 49'(RECIP100);
  assign q_mag  = 17'(q_prod >> RECIP100_SH);
  assign q_s    = p_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  always_comb begin
    if (vol == VOL_UNITY) begin
      res_d = val3_q;
    end else if (vol == '0) begin
      res_d = '0;
    end else if (fmt_q) begin
      res_d = $signed({8'd0, sat_byte(q_s + 18'sd128)});
    end else begin
      res_d = sat16(21'(q_s));
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    ch1_q  <= ch_q;
    s1_q   <= s0_val;
    f1_q   <= filt_act;
    ch2_q  <= ch1_q;
    val2_q <= val2_d;
    ch3_q  <= ch2_q;
    val3_q <= val2_q;
    p3_q   <= p2_d;
  end

  // Result collection: lanes beyond the active count stay at zero.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        res_q[i] <= '0;
      end
    end else if (v3_q) begin
      res_q[ch3_q[LANE_W-1:0]] <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        out_q[i] <= res_q[i];
      end
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] = out_q[i];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;

endmodule
